// ===== hdl/ohl_pkg.sv =====
// shared types and codes of the ordered handle list
package ohl_pkg;

    localparam int CMD_W      = 2;
    localparam int STATUS_W   = 2;
    localparam int READ_IDX_W = 4;
    localparam int COUNT_W    = 5;

    typedef enum logic [CMD_W-1:0] {
        CMD_ADD    = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_SWAP   = 2'd2,
        CMD_READ   = 2'd3
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_DONE = 2'd0,
        STATUS_MISS = 2'd1,
        STATUS_FULL = 2'd2
    } status_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic apply;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic out_free;
    } dp_stat_t;

endpackage

// ===== hdl/ohl_ctrl.sv =====
// control state machine of the ordered handle list
module ohl_ctrl
    import ohl_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_stall,
    input  dp_stat_t stat,
    output dp_cmd_t  ctl
);

    typedef enum logic {
        ST_IDLE,
        ST_APPLY
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   in_stall_reg;
    logic   in_stall_next;

    always_comb
    begin
        state_next    = state_reg;
        in_stall_next = in_stall_reg;
        ctl.load      = 1'b0;
        ctl.apply     = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    ctl.load      = 1'b1;
                    state_next    = ST_APPLY;
                    in_stall_next = 1'b1;
                end
            end
            ST_APPLY:
            begin
                // wait while an earlier result is still held at the output
                if (stat.out_free)
                begin
                    ctl.apply     = 1'b1;
                    state_next    = ST_IDLE;
                    in_stall_next = 1'b0;
                end
            end
            default:
            begin
                state_next    = ST_IDLE;
                in_stall_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            in_stall_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            in_stall_reg <= in_stall_next;
        end
    end

    assign in_stall = in_stall_reg;

endmodule

// ===== hdl/ohl_datapath.sv =====
// entry cells, match vectors, count and result register of the ordered handle list
module ohl_datapath
    import ohl_pkg::*;
#(
    parameter int LIST_DEPTH  = 16,
    parameter int HANDLE_BITS = 16
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  dp_cmd_t                ctl,
    output dp_stat_t               stat,
    input  logic [CMD_W-1:0]       cmd,
    input  logic [HANDLE_BITS-1:0] first_handle,
    input  logic [HANDLE_BITS-1:0] second_handle,
    input  logic [READ_IDX_W-1:0]  read_index,
    input  logic                   out_stall,
    output logic                   out_valid,
    output logic [STATUS_W-1:0]    status,
    output logic [COUNT_W-1:0]     entry_count,
    output logic [HANDLE_BITS-1:0] read_handle,
    output logic                   read_valid
);

    localparam int CNT_W = $clog2(LIST_DEPTH + 1);
    localparam int IDX_W = (CNT_W > READ_IDX_W) ? CNT_W : READ_IDX_W;
    localparam logic [LIST_DEPTH-1:0] ONES = '1;

    logic [HANDLE_BITS-1:0] entry_reg [LIST_DEPTH];
    logic [HANDLE_BITS-1:0] entry_next [LIST_DEPTH];
    logic [CNT_W-1:0]       count_reg;
    logic [CNT_W-1:0]       count_next;

    cmd_t                   op_reg;
    logic [HANDLE_BITS-1:0] h1_reg;
    logic [HANDLE_BITS-1:0] h2_reg;
    logic [READ_IDX_W-1:0]  idx_reg;
    logic [LIST_DEPTH-1:0]  m1_reg;
    logic [LIST_DEPTH-1:0]  m2_reg;
    logic [LIST_DEPTH-1:0]  m1_next;
    logic [LIST_DEPTH-1:0]  m2_next;

    logic                   out_valid_reg;
    status_t                status_reg;
    logic [COUNT_W-1:0]     entry_count_reg;
    logic [HANDLE_BITS-1:0] read_handle_reg;
    logic                   read_valid_reg;

    logic [LIST_DEPTH-1:0]  first1;
    logic [LIST_DEPTH-1:0]  first2;
    logic [LIST_DEPTH-1:0]  from_hit1;
    logic                   found1;
    logic                   found2;
    status_t                status_v;
    logic [HANDLE_BITS-1:0] rh_v;
    logic                   rv_v;

    // every live cell compares against both request handles at accept
    always_comb
    begin
        for (int i = 0; i < LIST_DEPTH; i++)
        begin
            m1_next[i] = (entry_reg[i] == first_handle) &&
                         (IDX_W'(i) < IDX_W'(count_reg));
            m2_next[i] = (entry_reg[i] == second_handle) &&
                         (IDX_W'(i) < IDX_W'(count_reg));
        end
    end

    // first hit per handle, and the cells at or after the first hit
    always_comb
    begin
        for (int i = 0; i < LIST_DEPTH; i++)
        begin
            first1[i]    = m1_reg[i] && ((m1_reg & (ONES >> (LIST_DEPTH - i))) == '0);
            first2[i]    = m2_reg[i] && ((m2_reg & (ONES >> (LIST_DEPTH - i))) == '0);
            from_hit1[i] = (m1_reg & (ONES >> (LIST_DEPTH - 1 - i))) != '0;
        end
        found1 = |m1_reg;
        found2 = |m2_reg;
    end

    always_comb
    begin
        entry_next = entry_reg;
        count_next = count_reg;
        status_v   = STATUS_DONE;
        rh_v       = '0;
        rv_v       = 1'b0;
        unique case (op_reg)
            CMD_ADD:
            begin
                if (count_reg == CNT_W'(LIST_DEPTH))
                begin
                    status_v = STATUS_FULL;
                end
                else
                begin
                    for (int i = 0; i < LIST_DEPTH; i++)
                    begin
                        if (CNT_W'(i) == count_reg)
                        begin
                            entry_next[i] = h1_reg;
                        end
                    end
                    count_next = count_reg + 1'b1;
                end
            end
            CMD_REMOVE:
            begin
                if (found1)
                begin
                    // close the gap: cells from the hit on take their right neighbor
                    for (int i = 0; i < LIST_DEPTH - 1; i++)
                    begin
                        if (from_hit1[i])
                        begin
                            entry_next[i] = entry_reg[i+1];
                        end
                    end
                    count_next = count_reg - 1'b1;
                end
                else
                begin
                    status_v = STATUS_MISS;
                end
            end
            CMD_SWAP:
            begin
                if (found1 && found2)
                begin
                    // values are known from the match, so each cell just takes the other handle
                    for (int i = 0; i < LIST_DEPTH; i++)
                    begin
                        if (first1[i])
                        begin
                            entry_next[i] = h2_reg;
                        end
                        if (first2[i])
                        begin
                            entry_next[i] = h1_reg;
                        end
                    end
                end
                else
                begin
                    status_v = STATUS_MISS;
                end
            end
            CMD_READ:
            begin
                if (IDX_W'(idx_reg) < IDX_W'(count_reg))
                begin
                    rv_v = 1'b1;
                    for (int i = 0; i < LIST_DEPTH; i++)
                    begin
                        if (IDX_W'(i) == IDX_W'(idx_reg))
                        begin
                            rh_v = entry_reg[i];
                        end
                    end
                end
                else
                begin
                    status_v = STATUS_MISS;
                end
            end
            default:
            begin
                status_v = STATUS_MISS;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            op_reg  <= cmd_t'(cmd);
            h1_reg  <= first_handle;
            h2_reg  <= second_handle;
            idx_reg <= read_index;
            m1_reg  <= m1_next;
            m2_reg  <= m2_next;
        end
        if (ctl.apply)
        begin
            entry_reg       <= entry_next;
            status_reg      <= status_v;
            entry_count_reg <= COUNT_W'(count_next);
            read_handle_reg <= rh_v;
            read_valid_reg  <= rv_v;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (ctl.apply)
            begin
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign stat.out_free = !out_valid_reg || !out_stall;

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign entry_count = entry_count_reg;
    assign read_handle = read_handle_reg;
    assign read_valid  = read_valid_reg;

endmodule

// ===== hdl/ordered_handle_list.sv =====
// ordered handle list: add, remove with compaction, swap and indexed read
//
// input channel (in_valid / in_stall) takes one request: cmd, first_handle,
// second_handle and read_index. output channel (out_valid / out_stall) gives
// one result per request: status, entry_count, read_handle and read_valid.
// a request is taken when valid is high and stall is low.
// the list lives in a row of LIST_DEPTH register cells; in the accept cycle
// every cell compares itself against both handles and the match vectors are
// registered; once the output is free, the cells shift, swap or load in
// parallel and the result register and out_valid are written.
// one request is in work at a time: in_stall stays high until its update.
// a result held by out_stall does not block the next accept; the update of
// that next request waits until the held result is taken.
// reset empties the list (count zero) and drops any pending result.
module ordered_handle_list
    import ohl_pkg::*;
#(
    parameter int LIST_DEPTH  = 16,
    parameter int HANDLE_BITS = 16
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [CMD_W-1:0]       cmd,
    input  logic [HANDLE_BITS-1:0] first_handle,
    input  logic [HANDLE_BITS-1:0] second_handle,
    input  logic [READ_IDX_W-1:0]  read_index,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [STATUS_W-1:0]    status,
    output logic [COUNT_W-1:0]     entry_count,
    output logic [HANDLE_BITS-1:0] read_handle,
    output logic                   read_valid
);

    dp_cmd_t  ctl;
    dp_stat_t stat;

    ohl_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .ctl      (ctl)
    );

    ohl_datapath #(
        .LIST_DEPTH  (LIST_DEPTH),
        .HANDLE_BITS (HANDLE_BITS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctl           (ctl),
        .stat          (stat),
        .cmd           (cmd),
        .first_handle  (first_handle),
        .second_handle (second_handle),
        .read_index    (read_index),
        .out_stall     (out_stall),
        .out_valid     (out_valid),
        .status        (status),
        .entry_count   (entry_count),
        .read_handle   (read_handle),
        .read_valid    (read_valid)
    );

endmodule

// ===== tb/sv/ohl_list_checker.sv =====
// request/result monitor with list predictor for the ordered handle list
module ohl_list_checker
    import ohl_pkg::*;
#(
    parameter int LIST_DEPTH  = 16,
    parameter int HANDLE_BITS = 16
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    input  logic                   in_stall,
    input  logic [CMD_W-1:0]       cmd,
    input  logic [HANDLE_BITS-1:0] first_handle,
    input  logic [HANDLE_BITS-1:0] second_handle,
    input  logic [READ_IDX_W-1:0]  read_index,
    input  logic                   out_valid,
    input  logic                   out_stall,
    input  logic [STATUS_W-1:0]    status,
    input  logic [COUNT_W-1:0]     entry_count,
    input  logic [HANDLE_BITS-1:0] read_handle,
    input  logic                   read_valid,
    output int                     fail_count,
    output int                     pending
);

    typedef struct packed {
        status_t                status;
        logic [COUNT_W-1:0]     count;
        logic [HANDLE_BITS-1:0] handle;
        logic                   valid;
    } list_result_t;

    logic [HANDLE_BITS-1:0] list_handles [LIST_DEPTH];
    int                     list_len;
    list_result_t           result_q [$];
    list_result_t           want;

    initial
    begin
        fail_count = 0;
        pending    = 0;
        list_len   = 0;
    end

    // position of the first entry equal to h, -1 when absent
    function automatic int find_first(logic [HANDLE_BITS-1:0] h);
        for (int i = 0; i < list_len; i++)
            if (list_handles[i] == h)
                return i;
        return -1;
    endfunction

    function automatic list_result_t apply_request(cmd_t op, logic [HANDLE_BITS-1:0] h1,
                                                   logic [HANDLE_BITS-1:0] h2,
                                                   logic [READ_IDX_W-1:0] idx);
        list_result_t           r;
        int                     p;
        int                     q;
        logic [HANDLE_BITS-1:0] t;
        r = '0;
        r.status = STATUS_DONE;
        case (op)
            CMD_ADD:
                if (list_len >= LIST_DEPTH)
                    r.status = STATUS_FULL;
                else
                begin
                    list_handles[list_len] = h1;
                    list_len++;
                end
            CMD_REMOVE:
            begin
                p = find_first(h1);
                if (p < 0)
                    r.status = STATUS_MISS;
                else
                begin
                    // close the gap
                    for (q = p; q < list_len - 1; q++)
                        list_handles[q] = list_handles[q + 1];
                    list_len--;
                end
            end
            CMD_SWAP:
            begin
                p = find_first(h1);
                q = find_first(h2);
                if (p < 0 || q < 0)
                    r.status = STATUS_MISS;
                else
                begin
                    t               = list_handles[p];
                    list_handles[p] = list_handles[q];
                    list_handles[q] = t;
                end
            end
            default:
                if (int'(idx) < list_len)
                begin
                    r.handle = list_handles[idx];
                    r.valid  = 1'b1;
                end
                else
                    r.status = STATUS_MISS;
        endcase
        r.count = list_len[COUNT_W-1:0];
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            list_len = 0;
            result_q.delete();
            pending = 0;
        end
        else
        begin
            // results first, so a stray result is never matched to this edge's request
            if (out_valid && !out_stall)
            begin
                if (result_q.size() == 0)
                begin
                    $error("result with no request pending");
                    fail_count++;
                end
                else
                begin
                    want = result_q.pop_front();
                    if (status !== want.status)
                    begin
                        $error("status: expected %0d, actual %0d", want.status, status);
                        fail_count++;
                    end
                    if (entry_count !== want.count)
                    begin
                        $error("entry_count: expected %0d, actual %0d", want.count, entry_count);
                        fail_count++;
                    end
                    if (read_handle !== want.handle)
                    begin
                        $error("read_handle: expected %h, actual %h", want.handle, read_handle);
                        fail_count++;
                    end
                    if (read_valid !== want.valid)
                    begin
                        $error("read_valid: expected %0d, actual %0d", want.valid, read_valid);
                        fail_count++;
                    end
                end
            end
            if (in_valid && !in_stall)
                result_q.push_back(apply_request(cmd_t'(cmd), first_handle, second_handle,
                                                 read_index));
            pending = result_q.size();
        end
    end

endmodule

// ===== tb/sv/tb_ordered_handle_list.sv =====
// stimulus, stall pattern and verdict for the ordered handle list
module tb_ordered_handle_list;
    import ohl_pkg::*;

    localparam int LIST_DEPTH  = 16;
    localparam int HANDLE_BITS = 16;
    localparam int IDLE_LIMIT  = 2000;
    localparam int RANDOM_REQS = 800;

    logic                   clk           = 1'b0;
    logic                   rst_n         = 1'b0;
    logic                   in_valid      = 1'b0;
    logic                   in_stall;
    logic [CMD_W-1:0]       cmd           = CMD_READ;
    logic [HANDLE_BITS-1:0] first_handle  = '0;
    logic [HANDLE_BITS-1:0] second_handle = '0;
    logic [READ_IDX_W-1:0]  read_index    = '0;
    logic                   out_valid;
    logic                   out_stall     = 1'b0;
    logic [STATUS_W-1:0]    status;
    logic [COUNT_W-1:0]     entry_count;
    logic [HANDLE_BITS-1:0] read_handle;
    logic                   read_valid;
    int                     fail_count;
    int                     pending;

    int                     burst_left  = 0;
    int                     stall_mode  = 0;
    int                     stall_phase = 0;
    int                     stall_left  = 0;
    int                     idle_cycles = 0;
    logic [HANDLE_BITS-1:0] handle_pool [8];

    ordered_handle_list #(
        .LIST_DEPTH (LIST_DEPTH),
        .HANDLE_BITS(HANDLE_BITS)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .cmd          (cmd),
        .first_handle (first_handle),
        .second_handle(second_handle),
        .read_index   (read_index),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .status       (status),
        .entry_count  (entry_count),
        .read_handle  (read_handle),
        .read_valid   (read_valid)
    );

    ohl_list_checker #(
        .LIST_DEPTH (LIST_DEPTH),
        .HANDLE_BITS(HANDLE_BITS)
    ) checker_i (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .cmd          (cmd),
        .first_handle (first_handle),
        .second_handle(second_handle),
        .read_index   (read_index),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .status       (status),
        .entry_count  (entry_count),
        .read_handle  (read_handle),
        .read_valid   (read_valid),
        .fail_count   (fail_count),
        .pending      (pending)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // receiver: switches between no stall, random stall and long stall runs
    always @(posedge clk)
    begin
        if (stall_phase == 0)
        begin
            stall_mode  = $urandom_range(0, 2);
            stall_phase = $urandom_range(50, 200);
        end
        else
            stall_phase--;
        case (stall_mode)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(0, 2) == 0);
            default:
                if (stall_left > 0)
                begin
                    stall_left--;
                    out_stall <= 1'b1;
                end
                else if ($urandom_range(0, 9) == 0)
                begin
                    stall_left = $urandom_range(3, 12);
                    out_stall <= 1'b1;
                end
                else
                    out_stall <= 1'b0;
        endcase
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles == IDLE_LIMIT)
            begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    // holds the request until taken, then either keeps the burst going or idles
    task automatic issue_request(cmd_t op, logic [HANDLE_BITS-1:0] h1,
                                 logic [HANDLE_BITS-1:0] h2, logic [READ_IDX_W-1:0] idx);
        in_valid      <= 1'b1;
        cmd           <= op;
        first_handle  <= h1;
        second_handle <= h2;
        read_index    <= idx;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (burst_left == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6))
                @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                      : $urandom_range(0, 6);
        end
        else
            burst_left--;
    endtask

    function automatic logic [HANDLE_BITS-1:0] rand_handle();
        return HANDLE_BITS'($urandom);
    endfunction

    function automatic logic [READ_IDX_W-1:0] rand_index();
        return READ_IDX_W'($urandom);
    endfunction

    // mostly handles from a small pool so removes and swaps find their targets
    function automatic logic [HANDLE_BITS-1:0] pick_handle();
        if ($urandom_range(0, 4) == 0)
            return rand_handle();
        return handle_pool[$urandom_range(0, 7)];
    endfunction

    initial
    begin
        logic [HANDLE_BITS-1:0] h;
        int                     roll;
        bit                     filling;

        repeat (8)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty list: every lookup misses
        issue_request(CMD_READ, rand_handle(), rand_handle(), 4'd0);
        issue_request(CMD_REMOVE, 16'h1234, rand_handle(), rand_index());
        issue_request(CMD_SWAP, 16'h1234, 16'h1234, rand_index());
        // fill to the top with extremes and a duplicate, then one add too many
        for (int i = 0; i < LIST_DEPTH; i++)
        begin
            h = (i == 0) ? 16'h0000 : (i == 1) ? 16'hFFFF :
                (i == 2 || i == 6) ? 16'h1234 : 16'h0100 + HANDLE_BITS'(i);
            issue_request(CMD_ADD, h, rand_handle(), rand_index());
        end
        issue_request(CMD_ADD, 16'hABCD, rand_handle(), rand_index());
        issue_request(CMD_READ, rand_handle(), rand_handle(), 4'd15);
        issue_request(CMD_SWAP, 16'hFFFF, 16'hFFFF, rand_index());
        issue_request(CMD_SWAP, 16'h0000, 16'hABCD, rand_index());
        issue_request(CMD_REMOVE, 16'hABCD, rand_handle(), rand_index());
        // duplicate: only the first copy goes
        issue_request(CMD_REMOVE, 16'h1234, rand_handle(), rand_index());
        issue_request(CMD_READ, rand_handle(), rand_handle(), 4'd15);
        issue_request(CMD_SWAP, 16'h0000, 16'h1234, rand_index());

        filling = 1'b0;
        for (int n = 0; n < RANDOM_REQS; n++)
        begin
            if (n % 100 == 0)
            begin
                filling = !filling;
                foreach (handle_pool[i])
                    handle_pool[i] = rand_handle();
                if ($urandom_range(0, 1))
                    handle_pool[0] = 16'h0000;
                if ($urandom_range(0, 1))
                    handle_pool[1] = 16'hFFFF;
            end
            roll = $urandom_range(0, 99);
            if (roll < (filling ? 45 : 20))
                issue_request(CMD_ADD, pick_handle(), rand_handle(), rand_index());
            else if (roll < (filling ? 65 : 60))
                issue_request(CMD_REMOVE, pick_handle(), rand_handle(), rand_index());
            else if (roll < (filling ? 80 : 75))
                issue_request(CMD_SWAP, pick_handle(), pick_handle(), rand_index());
            else
                issue_request(CMD_READ, rand_handle(), rand_handle(), rand_index());
        end
        in_valid <= 1'b0;
        @(posedge clk);

        wait (pending == 0);
        repeat (6)
            @(posedge clk);
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
